// ----- rtl/infix_to_postfix_converter_assert.svh -----
// Assertion macros for the infix to postfix converter checker.
// Every macro samples on the rising edge of clk.
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ITYP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ityp same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define ITYP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ityp next-cycle check failed");

// Holds in the cycle after reset is seen.
`define ITYP_ASSERT_RESET(name, cons) \
  name: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("ityp post-reset check failed");

`endif

// ----- rtl/ityp_pkg.sv -----
// ---------------------------------------------------------------------------
// ityp_pkg
// Types, character codes and operator helpers of the infix to postfix block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ityp_pkg;

  localparam int CHAR_W = 8;
  localparam int ERR_W  = 2;
  localparam int OP_W   = 3;

  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28; // (
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29; // )
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B; // +
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D; // -
  localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A; // *
  localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F; // /
  localparam logic [CHAR_W-1:0] CH_POW   = 8'h5E; // ^
  localparam logic [CHAR_W-1:0] CH_MOD   = 8'h25; // %
  localparam logic [CHAR_W-1:0] CH_SIN   = 8'h73; // s
  localparam logic [CHAR_W-1:0] CH_TERM  = 8'h78; // x
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // stack entry codes
  localparam logic [OP_W-1:0] OPC_OPEN  = 3'd0;
  localparam logic [OP_W-1:0] OPC_PLUS  = 3'd1;
  localparam logic [OP_W-1:0] OPC_MINUS = 3'd2;
  localparam logic [OP_W-1:0] OPC_MUL   = 3'd3;
  localparam logic [OP_W-1:0] OPC_DIV   = 3'd4;
  localparam logic [OP_W-1:0] OPC_POW   = 3'd5;
  localparam logic [OP_W-1:0] OPC_MOD   = 3'd6;
  localparam logic [OP_W-1:0] OPC_SIN   = 3'd7;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd2;

  typedef enum logic [2:0] {
    K_OPERAND,
    K_OPEN,
    K_CLOSE,
    K_LOW,
    K_HIGH
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [OP_W-1:0] code;
  } char_class_t;

  // stack shift control handed to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
    char_class_t r;
    r.kind = K_OPERAND;
    r.code = OPC_OPEN;
    case (c)
      CH_OPEN:  begin r.kind = K_OPEN;  r.code = OPC_OPEN;  end
      CH_CLOSE: begin r.kind = K_CLOSE; r.code = OPC_OPEN;  end
      CH_PLUS:  begin r.kind = K_LOW;   r.code = OPC_PLUS;  end
      CH_MINUS: begin r.kind = K_LOW;   r.code = OPC_MINUS; end
      CH_MUL:   begin r.kind = K_HIGH;  r.code = OPC_MUL;   end
      CH_DIV:   begin r.kind = K_HIGH;  r.code = OPC_DIV;   end
      CH_POW:   begin r.kind = K_HIGH;  r.code = OPC_POW;   end
      CH_MOD:   begin r.kind = K_HIGH;  r.code = OPC_MOD;   end
      CH_SIN:   begin r.kind = K_HIGH;  r.code = OPC_SIN;   end
      default:  begin r.kind = K_OPERAND; r.code = OPC_OPEN; end
    endcase
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] op_char(input logic [OP_W-1:0] code);
    logic [CHAR_W-1:0] r;
    case (code)
      OPC_OPEN:  r = CH_OPEN;
      OPC_PLUS:  r = CH_PLUS;
      OPC_MINUS: r = CH_MINUS;
      OPC_MUL:   r = CH_MUL;
      OPC_DIV:   r = CH_DIV;
      OPC_POW:   r = CH_POW;
      OPC_MOD:   r = CH_MOD;
      default:   r = CH_SIN;
    endcase
    return r;
  endfunction

  // does an incoming operator (or ')') pop this stack top
  function automatic logic op_pops(input kind_t k, input logic [OP_W-1:0] top);
    logic low_top;
    low_top = (top == OPC_PLUS) || (top == OPC_MINUS);
    return (top != OPC_OPEN) && !((k == K_HIGH) && low_top);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ityp_in_if.sv -----
// ---------------------------------------------------------------------------
// ityp_in_if
// Expression character channel: valid/ready with character and end flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ityp_in_if import ityp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;
  logic              end_expr;

  modport source (output valid, output in_char, output end_expr, input ready);
  modport sink   (input valid, input in_char, input end_expr, output ready);
endinterface

`default_nettype wire

// ----- rtl/ityp_out_if.sv -----
// ---------------------------------------------------------------------------
// ityp_out_if
// Postfix character channel: valid/ready with character, error and run end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ityp_out_if import ityp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic [ERR_W-1:0]  error_code;
  logic              last_of_run;

  modport source (output valid, output out_char, output error_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_char, input error_code,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/ityp_cell.sv -----
// ---------------------------------------------------------------------------
// ityp_cell
// One operator stack slot: takes the upper neighbor on push, lower on pop.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ityp_cell import ityp_pkg::*; (
  input  logic            clk,
  input  stk_ctrl_t       ctrl,
  input  logic [OP_W-1:0] push_in,
  input  logic [OP_W-1:0] pop_in,
  output logic [OP_W-1:0] q
);

  // contents undefined until written; the fill count says what is live
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      q <= push_in;
    end else if (ctrl.pop) begin
      q <= pop_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/infix_to_postfix_converter.sv -----
// ---------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters out,
// operators held in a shifting chain of stack cells.
// ---------------------------------------------------------------------------
//
//   channel   modport  payload                              per transfer
//   expr      sink     in_char[7:0], end_expr               one character
//   postfix   source   out_char[7:0], error_code[1:0],      one output char
//                      last_of_run
//
// Sequence: the sequencer takes a character, then emits its results. An
//   operand gives the character; an operator gives a space after an operand,
//   one result per popped entry, then a quiet step to close the pop loop (a
//   push, a dropped '(' or nothing); an end of expression adds the space slot,
//   one result per entry, a step to see the stack empty, and the 'x'.
//   The sequencer and the single output register set the pace.
// Reset: clears control and the fill count; stack cells need no clearing.
// Stalls: the output register holds while postfix.ready is low and the
//   sequencer waits; a new character is taken once the last result of the
//   previous one is loaded, even if it has not yet been taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter import ityp_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  ityp_in_if.sink     expr,
  ityp_out_if.source  postfix
);

  localparam int CW      = $clog2(STACK_DEPTH + 1);   // fill count width
  localparam int MAX_RES = STACK_DEPTH + 3;           // results per item cap
  localparam int NW      = $clog2(MAX_RES + 1);       // result counter width
  localparam int SW      = ((NW > CW) ? NW : CW) + 1; // space check sum width

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for a character
  localparam logic [2:0] S_CHAR   = 3'd1;  // pass operand through
  localparam logic [2:0] S_SPACE  = 3'd2;  // separator after an operand
  localparam logic [2:0] S_OPS    = 3'd3;  // pop loop, then push / drop '('
  localparam logic [2:0] S_FSPACE = 3'd4;  // space ahead of the flush
  localparam logic [2:0] S_FLUSH  = 3'd5;  // drain stack, top first
  localparam logic [2:0] S_TERM   = 3'd6;  // closing 'x'

  logic [2:0]        state, state_next;
  logic [CW-1:0]     count, count_next;         // live stack entries
  logic [CW-1:0]     paren_cnt, paren_cnt_next; // '(' entries on the stack
  logic              prev_op, prev_op_next;     // last char was an operand
  logic [ERR_W-1:0]  err, err_next;             // sticky error of expression
  logic [NW-1:0]     n_emit, n_emit_next;       // results of current item

  // current character, latched at the input transfer
  logic [CHAR_W-1:0] cur_char;
  kind_t             cur_kind;
  logic [OP_W-1:0]   cur_code;
  logic              cur_end;

  // output register
  logic              out_valid;
  logic [CHAR_W-1:0] out_char_r;
  logic [ERR_W-1:0]  out_err_r;
  logic              out_last_r;

  logic              emit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  stk_ctrl_t         ctrl;

  logic [OP_W-1:0]   cell_q [STACK_DEPTH];

  char_class_t       in_cls;
  logic              accept;
  logic              can_emit;
  logic              empty, full;
  logic              top_pops;   // current operator pops the top entry
  logic              next_pops;  // ...and would pop the one below it
  logic              in_pops;    // incoming operator pops the top entry
  logic              space_ok;
  logic [SW-1:0]     space_sum;

  assign in_cls   = classify(expr.in_char);
  assign accept   = (state == S_IDLE) && expr.valid;
  assign can_emit = !out_valid || postfix.ready;
  assign empty    = (count == '0);
  assign full     = (count == CW'(STACK_DEPTH));

  // ')' uses the same stop rule as '+' and '-': stop only at '('
  assign top_pops  = !empty && (cur_kind != K_OPEN) && op_pops(cur_kind, cell_q[0]);
  assign next_pops = (count > CW'(1)) && op_pops(cur_kind, cell_q[1]);
  assign in_pops   = !empty && op_pops(in_cls.kind, cell_q[0]);

  // the space before the flush is dropped only when it would exceed the cap
  assign space_sum = SW'(n_emit) + SW'(count) + SW'(2);
  assign space_ok  = (space_sum <= SW'(MAX_RES));

  assign expr.ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    count_next     = count;
    paren_cnt_next = paren_cnt;
    prev_op_next   = prev_op;
    err_next       = err;
    n_emit_next    = n_emit;
    ctrl           = '0;
    emit           = 1'b0;
    emit_char      = cur_char;
    emit_last      = 1'b0;

    case (state)
      S_IDLE: begin
        if (expr.valid) begin
          n_emit_next  = '0;
          prev_op_next = (in_cls.kind == K_OPERAND);
          // the error is known up front: a push overflows only when the
          // operator pops nothing from a full stack
          if (err == ERR_OK) begin
            if ((in_cls.kind == K_OPEN) && full) begin
              err_next = ERR_OVERFLOW;
            end else if (((in_cls.kind == K_LOW) || (in_cls.kind == K_HIGH)) &&
                         full && !in_pops) begin
              err_next = ERR_OVERFLOW;
            end else if ((in_cls.kind == K_CLOSE) && (paren_cnt == '0)) begin
              err_next = ERR_UNMATCHED;
            end
          end
          if (in_cls.kind == K_OPERAND) begin
            state_next = S_CHAR;
          end else if (prev_op) begin
            state_next = S_SPACE;
          end else begin
            state_next = S_OPS;
          end
        end
      end

      S_CHAR: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_char  = cur_char;
          emit_last  = !cur_end;
          state_next = cur_end ? S_FSPACE : S_IDLE;
        end
      end

      S_SPACE: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_char  = CH_SPACE;
          emit_last  = !cur_end && !top_pops;
          state_next = S_OPS;
        end
      end

      S_OPS: begin
        if (top_pops) begin
          if (can_emit) begin
            emit       = 1'b1;
            emit_char  = op_char(cell_q[0]);
            emit_last  = !cur_end && !next_pops;
            ctrl.pop   = 1'b1;
            count_next = count - CW'(1);
          end
        end else begin
          case (cur_kind)
            K_CLOSE: begin
              // top is the matching '(' unless the stack ran dry
              if (!empty) begin
                ctrl.pop       = 1'b1;
                count_next     = count - CW'(1);
                paren_cnt_next = paren_cnt - CW'(1);
              end
            end
            K_OPEN, K_LOW, K_HIGH: begin
              if (!full) begin
                ctrl.push  = 1'b1;
                count_next = count + CW'(1);
                if (cur_kind == K_OPEN) begin
                  paren_cnt_next = paren_cnt + CW'(1);
                end
              end
            end
            default: begin
            end
          endcase
          state_next = cur_end ? S_FSPACE : S_IDLE;
        end
      end

      S_FSPACE: begin
        if (!space_ok) begin
          state_next = S_FLUSH;
        end else if (can_emit) begin
          emit       = 1'b1;
          emit_char  = CH_SPACE;
          state_next = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (empty) begin
          state_next = S_TERM;
        end else if (can_emit) begin
          emit       = 1'b1;
          emit_char  = op_char(cell_q[0]);
          ctrl.pop   = 1'b1;
          count_next = count - CW'(1);
        end
      end

      S_TERM: begin
        if (can_emit) begin
          emit           = 1'b1;
          emit_char      = CH_TERM;
          emit_last      = 1'b1;
          count_next     = '0;
          paren_cnt_next = '0;
          prev_op_next   = 1'b0;
          err_next       = ERR_OK;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (emit) begin
      n_emit_next = n_emit + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      paren_cnt <= '0;
      prev_op   <= 1'b0;
      err       <= ERR_OK;
      n_emit    <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      paren_cnt <= paren_cnt_next;
      prev_op   <= prev_op_next;
      err       <= err_next;
      n_emit    <= n_emit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_char <= expr.in_char;
      cur_kind <= in_cls.kind;
      cur_code <= in_cls.code;
      cur_end  <= expr.end_expr;
    end
  end

  // output register: error is the expression's latch after this item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (postfix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= emit_char;
      out_err_r  <= err;
      out_last_r <= emit_last;
    end
  end

  assign postfix.valid       = out_valid;
  assign postfix.out_char    = out_char_r;
  assign postfix.error_code  = out_err_r;
  assign postfix.last_of_run = out_last_r;

  // operator stack: cell 0 is the top, entries shift one place per push/pop
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [OP_W-1:0] push_src;
    logic [OP_W-1:0] pop_src;

    if (i == 0) begin : g_top
      assign push_src = cur_code;
    end else begin : g_mid
      assign push_src = cell_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign pop_src = cell_q[i];
    end else begin : g_up
      assign pop_src = cell_q[i+1];
    end

    ityp_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .push_in (push_src),
      .pop_in  (pop_src),
      .q       (cell_q[i])
    );
  end

endmodule

`default_nettype wire

// ----- rtl/ityp_checker.sv -----
// ---------------------------------------------------------------------------
// ityp_checker
// Port-level checks on the converter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "infix_to_postfix_converter_assert.svh"

module ityp_checker import ityp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ERR_W-1:0] error_code,
  input logic             last_of_run
);

  // stalled result stays offered
  `ITYP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // only the three defined codes appear
  `ITYP_ASSERT_IMPL(a_err_code, out_valid, (error_code == ERR_OK) || (error_code == ERR_OVERFLOW) || (error_code == ERR_UNMATCHED))
  // one character at a time: busy right after a transfer
  `ITYP_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
  // no new character while the current one still has results to give
  `ITYP_ASSERT_IMPL(a_no_in_mid_run, out_valid && !last_of_run, !in_ready)
  // output register empty out of reset
  `ITYP_ASSERT_RESET(a_reset_quiet, !out_valid)

endmodule

bind infix_to_postfix_converter ityp_checker u_ityp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (expr.valid),
  .in_ready    (expr.ready),
  .out_valid   (postfix.valid),
  .out_ready   (postfix.ready),
  .error_code  (postfix.error_code),
  .last_of_run (postfix.last_of_run)
);

`default_nettype wire
